// File: rtl/core/sat_pkg.sv
// Shared constants and types for the suffix automaton builder.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
package sat_pkg;
   localparam int MAX_LEN_DEF  = 4096;
   localparam int ALPHABET_DEF = 26;
   localparam int SYM_W        = 5;
   localparam int COUNT_W      = 24;

   typedef enum logic [16:0] {
      ST_IDLE  = 17'b00000000000000001,
      ST_CLR   = 17'b00000000000000010,
      ST_UBASE = 17'b00000000000000100,
      ST_UCLR  = 17'b00000000000001000,
      ST_WADDR = 17'b00000000000010000,
      ST_WRD   = 17'b00000000000100000,
      ST_WCHK  = 17'b00000000001000000,
      ST_QRD   = 17'b00000000010000000,
      ST_QCHK  = 17'b00000000100000000,
      ST_QBASE = 17'b00000001000000000,
      ST_VBASE = 17'b00000010000000000,
      ST_COPY  = 17'b00000100000000000,
      ST_LINK  = 17'b00001000000000000,
      ST_RADDR = 17'b00010000000000000,
      ST_RRD   = 17'b00100000000000000,
      ST_RCHK  = 17'b01000000000000000,
      ST_FIN   = 17'b10000000000000000
   } state_type;
endpackage

// File: rtl/core/sat_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/core/suffix_automaton_builder.sv
// Top level of the suffix automaton builder: sequencer and state registers.
// Depends on sat_pkg and two sat_ram instances (transition table, node table).
//
// Usage: the req channel carries one item per transfer, kind in req_tuser
// (1 clears the automaton) and the symbol in req_tdata. Every item gives one
// transfer on the rsp channel with the running count of distinct substrings
// and an overflow flag for a symbol dropped because the text is full.
// One item is in work at a time; req_tready is high only while the sequencer
// waits. An append walks the suffix links, and a clone also redirects links:
// each new state clears its transition row one entry per cycle, a clone
// copies a row at the same pace, and each link step is one address, read and
// check round trip on the memories. A clear sweeps rows 0 and 1 of the
// transition table; an ignored or dropped symbol goes straight to its result.
// After reset the block sweeps rows 0 and 1 of the transition table and
// accepts no item meanwhile. A finished result waits in the output register
// while the receiver stalls; the next item is accepted meanwhile and its
// result waits until the register is free.
`timescale 1ns / 1ps
module suffix_automaton_builder #(
   parameter int MAX_LEN  = sat_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = sat_pkg::ALPHABET_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [4:0] symbol, [7:5] zero
   input  logic        req_tuser,  // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [23:0] distinct_count
   output logic        rsp_tuser   // [0] overflow
);
   localparam int NSTATES = 2 * MAX_LEN + 2;
   localparam int SW      = $clog2(NSTATES);
   localparam int LW      = $clog2(MAX_LEN + 1);
   localparam int AW      = $clog2(NSTATES * ALPHABET);
   localparam int KW      = $clog2(2 * ALPHABET + 1);
   localparam int NW      = SW + LW;
   localparam int CW      = sat_pkg::COUNT_W;

   sat_pkg::state_type state_ff, state_in;
   logic [SW-1:0] p_ff, p_in, u_ff, u_in, q_ff, q_in, v_ff, v_in;
   logic [SW-1:0] last_ff, last_in, count_ff, count_in, plink_ff, plink_in;
   logic [SW-1:0] linku_ff, linku_in;
   logic [LW-1:0] tlen_ff, tlen_in, lenp_ff, lenp_in, lenq_ff, lenq_in;
   logic [LW-1:0] lenlink_ff, lenlink_in;
   logic [CW-1:0] total_ff, total_in;
   logic [AW-1:0] taddr_ff, taddr_in, base_ff, base_in, vbase_ff, vbase_in;
   logic [KW-1:0] k_ff, k_in;
   logic [sat_pkg::SYM_W-1:0] c_ff, c_in;
   logic emit_ff, emit_in, flag_ff, flag_in;
   logic rvalid_ff, rvalid_in, ruser_ff, ruser_in;
   logic [CW-1:0] rdata_ff, rdata_in;

   logic          t_we, n_we;
   logic [AW-1:0] t_waddr, t_raddr;
   logic [SW-1:0] t_wdata, t_rdata;
   logic [SW-1:0] n_waddr, n_raddr;
   logic [NW-1:0] n_wdata, n_rdata;
   logic [SW-1:0] n_link;
   logic [LW-1:0] n_len;
   logic          slot_free;

   assign n_link     = n_rdata[NW-1:LW];
   assign n_len      = n_rdata[LW-1:0];
   assign slot_free  = !rvalid_ff || rsp_tready;
   assign req_tready = (state_ff == sat_pkg::ST_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;

   sat_ram #(.WIDTH(SW), .DEPTH(NSTATES * ALPHABET)) u_trans (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_addr(t_raddr), .rd_data(t_rdata)
   );

   sat_ram #(.WIDTH(NW), .DEPTH(NSTATES)) u_node (
      .clock(clock), .wr_en(n_we), .wr_addr(n_waddr), .wr_data(n_wdata),
      .rd_addr(n_raddr), .rd_data(n_rdata)
   );

   assign t_raddr = (state_ff == sat_pkg::ST_COPY) ? base_ff + AW'(k_ff) : taddr_ff;
   assign n_raddr = (state_ff == sat_pkg::ST_QRD) ? q_ff : p_ff;

   always_comb begin
      state_in   = state_ff;
      p_in       = p_ff;
      u_in       = u_ff;
      q_in       = q_ff;
      v_in       = v_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      plink_in   = plink_ff;
      linku_in   = linku_ff;
      tlen_in    = tlen_ff;
      lenp_in    = lenp_ff;
      lenq_in    = lenq_ff;
      lenlink_in = lenlink_ff;
      total_in   = total_ff;
      taddr_in   = taddr_ff;
      base_in    = base_ff;
      vbase_in   = vbase_ff;
      k_in       = k_ff;
      c_in       = c_ff;
      emit_in    = emit_ff;
      flag_in    = flag_ff;
      rvalid_in  = rvalid_ff && !rsp_tready;
      rdata_in   = rdata_ff;
      ruser_in   = ruser_ff;
      t_we       = 1'b0;
      t_waddr    = taddr_ff;
      t_wdata    = '0;
      n_we       = 1'b0;
      n_waddr    = u_ff;
      n_wdata    = '0;
      case (state_ff)
         sat_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               c_in    = req_tdata[sat_pkg::SYM_W-1:0];
               flag_in = 1'b0;
               emit_in = 1'b1;
               if (req_tuser) begin
                  last_in  = SW'(1);
                  count_in = SW'(1);
                  total_in = '0;
                  tlen_in  = '0;
                  k_in     = '0;
                  state_in = sat_pkg::ST_CLR;
               end else if (32'(tlen_ff) >= MAX_LEN) begin
                  flag_in  = 1'b1;
                  state_in = sat_pkg::ST_FIN;
               end else if (32'(req_tdata[sat_pkg::SYM_W-1:0]) < ALPHABET) begin
                  u_in     = count_ff + SW'(1);
                  count_in = count_ff + SW'(1);
                  p_in     = last_ff;
                  state_in = sat_pkg::ST_UBASE;
               end else begin
                  state_in = sat_pkg::ST_FIN;
               end
            end
         end
         sat_pkg::ST_CLR: begin
            t_we    = 1'b1;
            t_waddr = AW'(k_ff);
            n_we    = (k_ff == '0);
            n_waddr = SW'(1);
            k_in    = k_ff + KW'(1);
            if (32'(k_ff) == 2 * ALPHABET - 1) begin
               state_in = emit_ff ? sat_pkg::ST_FIN : sat_pkg::ST_IDLE;
            end
         end
         sat_pkg::ST_UBASE: begin
            base_in = AW'(u_ff) * AW'(ALPHABET);
            n_we    = 1'b1;
            n_waddr = u_ff;
            n_wdata = {SW'(0), tlen_ff + LW'(1)};
            k_in    = '0;
            state_in = sat_pkg::ST_UCLR;
         end
         sat_pkg::ST_UCLR: begin
            t_we    = 1'b1;
            t_waddr = base_ff + AW'(k_ff);
            k_in    = k_ff + KW'(1);
            if (32'(k_ff) == ALPHABET - 1) begin
               state_in = sat_pkg::ST_WADDR;
            end
         end
         sat_pkg::ST_WADDR: begin
            taddr_in = AW'(p_ff) * AW'(ALPHABET) + AW'(c_ff);
            state_in = sat_pkg::ST_WRD;
         end
         sat_pkg::ST_WRD: begin
            state_in = sat_pkg::ST_WCHK;
         end
         sat_pkg::ST_WCHK: begin
            lenp_in  = n_len;
            plink_in = n_link;
            if (t_rdata == '0) begin
               t_we    = 1'b1;
               t_wdata = u_ff;
               p_in    = n_link;
               if (n_link == '0) begin
                  linku_in   = SW'(1);
                  lenlink_in = '0;
                  state_in   = sat_pkg::ST_FIN;
               end else begin
                  state_in = sat_pkg::ST_WADDR;
               end
            end else begin
               q_in     = t_rdata;
               state_in = sat_pkg::ST_QRD;
            end
         end
         sat_pkg::ST_QRD: begin
            state_in = sat_pkg::ST_QCHK;
         end
         sat_pkg::ST_QCHK: begin
            lenq_in = n_len;
            if (n_len == lenp_ff + LW'(1)) begin
               linku_in   = q_ff;
               lenlink_in = n_len;
               state_in   = sat_pkg::ST_FIN;
            end else begin
               v_in       = count_ff + SW'(1);
               count_in   = count_ff + SW'(1);
               linku_in   = count_ff + SW'(1);
               lenlink_in = lenp_ff + LW'(1);
               n_we       = 1'b1;
               n_waddr    = count_ff + SW'(1);
               n_wdata    = {n_link, lenp_ff + LW'(1)};
               state_in   = sat_pkg::ST_QBASE;
            end
         end
         sat_pkg::ST_QBASE: begin
            base_in  = AW'(q_ff) * AW'(ALPHABET);
            state_in = sat_pkg::ST_VBASE;
         end
         sat_pkg::ST_VBASE: begin
            vbase_in = AW'(v_ff) * AW'(ALPHABET);
            k_in     = '0;
            state_in = sat_pkg::ST_COPY;
         end
         sat_pkg::ST_COPY: begin
            k_in = k_ff + KW'(1);
            if (k_ff != '0) begin
               t_we    = 1'b1;
               t_waddr = vbase_ff + AW'(k_ff) - AW'(1);
               t_wdata = t_rdata;
            end
            if (32'(k_ff) == ALPHABET) begin
               state_in = sat_pkg::ST_LINK;
            end
         end
         sat_pkg::ST_LINK: begin
            n_we    = 1'b1;
            n_waddr = q_ff;
            n_wdata = {v_ff, lenq_ff};
            t_we    = 1'b1;
            t_wdata = v_ff;
            p_in    = plink_ff;
            state_in = (plink_ff == '0) ? sat_pkg::ST_FIN : sat_pkg::ST_RADDR;
         end
         sat_pkg::ST_RADDR: begin
            taddr_in = AW'(p_ff) * AW'(ALPHABET) + AW'(c_ff);
            state_in = sat_pkg::ST_RRD;
         end
         sat_pkg::ST_RRD: begin
            state_in = sat_pkg::ST_RCHK;
         end
         sat_pkg::ST_RCHK: begin
            if (t_rdata == q_ff) begin
               t_we    = 1'b1;
               t_wdata = v_ff;
               p_in    = n_link;
               state_in = (n_link == '0) ? sat_pkg::ST_FIN : sat_pkg::ST_RADDR;
            end else begin
               state_in = sat_pkg::ST_FIN;
            end
         end
         sat_pkg::ST_FIN: begin
            if (emit_ff) begin
               if (slot_free) begin
                  rvalid_in = 1'b1;
                  rdata_in  = total_ff;
                  ruser_in  = flag_ff;
                  emit_in   = 1'b0;
                  state_in  = sat_pkg::ST_IDLE;
               end
            end else begin
               n_we     = 1'b1;
               n_waddr  = u_ff;
               n_wdata  = {linku_ff, tlen_ff + LW'(1)};
               last_in  = u_ff;
               total_in = total_ff + CW'(tlen_ff + LW'(1)) - CW'(lenlink_ff);
               tlen_in  = tlen_ff + LW'(1);
               emit_in  = 1'b1;
            end
         end
         default: begin
            state_in = sat_pkg::ST_IDLE;
         end
      endcase
      if (state_ff == sat_pkg::ST_IDLE && req_tvalid && !req_tuser &&
          32'(tlen_ff) < MAX_LEN && 32'(req_tdata[sat_pkg::SYM_W-1:0]) < ALPHABET) begin
         emit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sat_pkg::ST_CLR;
         k_ff      <= '0;
         emit_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
         last_ff   <= SW'(1);
         count_ff  <= SW'(1);
         total_ff  <= '0;
         tlen_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         emit_ff   <= emit_in;
         rvalid_ff <= rvalid_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         tlen_ff   <= tlen_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      u_ff       <= u_in;
      q_ff       <= q_in;
      v_ff       <= v_in;
      plink_ff   <= plink_in;
      linku_ff   <= linku_in;
      lenp_ff    <= lenp_in;
      lenq_ff    <= lenq_in;
      lenlink_ff <= lenlink_in;
      taddr_ff   <= taddr_in;
      base_ff    <= base_in;
      vbase_ff   <= vbase_in;
      c_ff       <= c_in;
      flag_ff    <= flag_in;
      rdata_ff   <= rdata_in;
      ruser_ff   <= ruser_in;
   end
endmodule

// File: rtl/core/sat_checker.sv
// Port-level checks for the suffix automaton builder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module sat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared in the cycle after a transfer");
endmodule

bind suffix_automaton_builder sat_checker u_sat_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
